>>> design/assert_macros.svh
// Assertion macros used by the dictionary core datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/sdict_pkg.sv
// Shared constants and types for the schema dictionary core
`timescale 1ns / 1ps

package sdict_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int HDR_BYTES   = 12;
    localparam int ENT_BYTES   = 10;
    localparam int SLOT_W      = $clog2(ENT_BYTES);
    localparam int BCNT_W      = 20;
    localparam int EIDX_W      = 17;
    localparam int KEY_W       = 24;
    localparam int LINK_W      = 56;

    localparam logic MODE_BLOB   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] LS_OK        = 2'd0;
    localparam logic [1:0] LS_SHORT     = 2'd1;
    localparam logic [1:0] LS_TRUNCATED = 2'd2;
    localparam logic [1:0] LS_CAPACITY  = 2'd3;

    typedef struct packed {
        logic take_byte;
        logic look_start;
        logic read_next;
        logic emit_load;
        logic emit_hit;
        logic emit_miss;
    } cmd_t;

    typedef struct packed {
        logic range_empty;
        logic hit;
        logic more;
    } sts_t;

endpackage

>>> design/schema_dictionary_load_and_lookup_core.sv
// Top level of the schema dictionary load and lookup core
`timescale 1ns / 1ps

// Usage:
//   Drive an item and raise start; it transfers at a clock edge where busy is low.
//   mode 0 carries one dictionary blob byte; last_byte marks the final byte.
//   Blob bytes can follow back to back. The final byte yields a load status
//   result on the next cycle; a failed load empties the table.
//   mode 1 is a lookup: the cluster [cluster_start, cluster_start + cluster_count),
//   clipped to the loaded entry count, is scanned for the first entry whose
//   sequence equals seq_key, one entry per cycle from the table memory.
//   A lookup holds busy while it scans entries; the result shows in the cycle
//   after the scan ends; an empty cluster gives a miss without raising busy.
//   Each result transfers on the single cycle where done is high; the receiver
//   cannot stall, so it must take it then.
//   Reset empties the table and clears the byte count; table contents are
//   not cleared and are only read below the loaded count.
module schema_dictionary_load_and_lookup_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  blob_byte,
    input  logic        last_byte,
    input  logic [15:0] cluster_start,
    input  logic [15:0] cluster_count,
    input  logic [15:0] seq_key,
    output logic        done,
    output logic        result_kind,
    output logic [1:0]  load_status,
    output logic        found,
    output logic [7:0]  entry_index,
    output logic [7:0]  entry_format,
    output logic [15:0] entry_seq,
    output logic [15:0] child_offset,
    output logic [15:0] child_count,
    output logic [7:0]  name_length,
    output logic [15:0] name_offset
);

    sdict_pkg::cmd_t cmd;
    sdict_pkg::sts_t sts;

    sdict_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .last_byte (last_byte),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    sdict_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .blob_byte     (blob_byte),
        .cluster_start (cluster_start),
        .cluster_count (cluster_count),
        .seq_key       (seq_key),
        .done          (done),
        .result_kind   (result_kind),
        .load_status   (load_status),
        .found         (found),
        .entry_index   (entry_index),
        .entry_format  (entry_format),
        .entry_seq     (entry_seq),
        .child_offset  (child_offset),
        .child_count   (child_count),
        .name_length   (name_length),
        .name_offset   (name_offset)
    );

endmodule

>>> design/sdict_ctrl.sv
// Controller state machine for the schema dictionary core
`timescale 1ns / 1ps

module sdict_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  logic             last_byte,
    input  sdict_pkg::sts_t  sts,
    output sdict_pkg::cmd_t  cmd,
    output logic             busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == sdict_pkg::MODE_BLOB)
                    begin
                        cmd.take_byte = 1'b1;
                        cmd.emit_load = last_byte;
                    end
                    else if (sts.range_empty)
                    begin
                        cmd.emit_miss = 1'b1;
                    end
                    else
                    begin
                        cmd.look_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.emit_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (sts.more)
                begin
                    cmd.read_next = 1'b1;
                end
                else
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/sdict_dp.sv
// Datapath for the schema dictionary core: blob unpacking, entry table, cluster scan
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdict_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  sdict_pkg::cmd_t  cmd,
    output sdict_pkg::sts_t  sts,
    input  logic [7:0]       blob_byte,
    input  logic [15:0]      cluster_start,
    input  logic [15:0]      cluster_count,
    input  logic [15:0]      seq_key,
    output logic             done,
    output logic             result_kind,
    output logic [1:0]       load_status,
    output logic             found,
    output logic [7:0]       entry_index,
    output logic [7:0]       entry_format,
    output logic [15:0]      entry_seq,
    output logic [15:0]      child_offset,
    output logic [15:0]      child_count,
    output logic [7:0]       name_length,
    output logic [15:0]      name_offset
);

    localparam logic [sdict_pkg::BCNT_W-1:0] BCNT_MAX = '1;

    logic [sdict_pkg::BCNT_W-1:0] byte_cnt_reg;
    logic [sdict_pkg::BCNT_W-1:0] byte_cnt_inc;
    logic [sdict_pkg::SLOT_W-1:0] slot_reg;
    logic [sdict_pkg::EIDX_W-1:0] eidx_reg;
    logic [15:0]                  declared_reg;
    logic [sdict_pkg::CNT_W-1:0]  loaded_reg;
    logic [7:0]                   assembly_reg [sdict_pkg::ENT_BYTES-1];

    logic [sdict_pkg::KEY_W-1:0]  key_mem  [sdict_pkg::MAX_ENTRIES];
    logic [sdict_pkg::LINK_W-1:0] link_mem [sdict_pkg::MAX_ENTRIES];
    logic [sdict_pkg::KEY_W-1:0]  key_rd_reg;
    logic [sdict_pkg::LINK_W-1:0] link_rd_reg;

    logic [sdict_pkg::IDX_W-1:0]  rd_idx_reg;
    logic [sdict_pkg::IDX_W-1:0]  rd_addr;
    logic                         rd_en;
    logic [sdict_pkg::CNT_W-1:0]  end_reg;
    logic [15:0]                  key_reg;

    logic                         in_entries;
    logic                         unsat;
    logic                         wr_en;
    logic [sdict_pkg::KEY_W-1:0]  wr_key;
    logic [sdict_pkg::LINK_W-1:0] wr_link;
    logic [20:0]                  need_len;
    logic [1:0]                   status;
    logic [16:0]                  cl_sum;
    logic [sdict_pkg::CNT_W-1:0]  cl_end;
    logic [sdict_pkg::CNT_W:0]    rd_idx_inc;

    logic                         done_reg;
    logic                         kind_reg;
    logic [1:0]                   status_reg;
    logic                         found_reg;
    logic [7:0]                   index_reg;
    logic [7:0]                   fmt_reg;
    logic [15:0]                  seq_reg;
    logic [15:0]                  coff_reg;
    logic [15:0]                  ccnt_reg;
    logic [7:0]                   nlen_reg;
    logic [15:0]                  noff_reg;

    // load side
    assign unsat        = (byte_cnt_reg != BCNT_MAX);
    assign byte_cnt_inc = unsat ? byte_cnt_reg + 1'b1 : byte_cnt_reg;
    assign in_entries   = (byte_cnt_reg >= sdict_pkg::BCNT_W'(sdict_pkg::HDR_BYTES));
    assign wr_en = cmd.take_byte && in_entries
                   && (slot_reg == sdict_pkg::SLOT_W'(sdict_pkg::ENT_BYTES - 1))
                   && (eidx_reg < {1'b0, declared_reg})
                   && (eidx_reg < sdict_pkg::EIDX_W'(sdict_pkg::MAX_ENTRIES));
    assign wr_key  = {assembly_reg[0], assembly_reg[2], assembly_reg[1]};
    assign wr_link = {assembly_reg[4], assembly_reg[3], assembly_reg[6], assembly_reg[5],
                      assembly_reg[7], blob_byte, assembly_reg[8]};

    assign need_len = 21'(sdict_pkg::HDR_BYTES) + {2'b00, declared_reg, 3'b000}
                      + {4'b0000, declared_reg, 1'b0};

    always_comb
    begin
        if (byte_cnt_inc < sdict_pkg::BCNT_W'(sdict_pkg::HDR_BYTES))
        begin
            status = sdict_pkg::LS_SHORT;
        end
        else if ({1'b0, byte_cnt_inc} < need_len)
        begin
            status = sdict_pkg::LS_TRUNCATED;
        end
        else if ({1'b0, declared_reg} > 17'(sdict_pkg::MAX_ENTRIES))
        begin
            status = sdict_pkg::LS_CAPACITY;
        end
        else
        begin
            status = sdict_pkg::LS_OK;
        end
    end

    // lookup side
    assign cl_sum     = {1'b0, cluster_start} + {1'b0, cluster_count};
    assign cl_end     = (cl_sum < 17'(loaded_reg)) ? sdict_pkg::CNT_W'(cl_sum) : loaded_reg;
    assign rd_idx_inc = (sdict_pkg::CNT_W + 1)'(rd_idx_reg) + 1'b1;
    assign rd_en      = cmd.look_start || cmd.read_next;
    assign rd_addr    = cmd.look_start ? sdict_pkg::IDX_W'(cluster_start)
                                       : sdict_pkg::IDX_W'(rd_idx_inc);

    assign sts.range_empty = ({1'b0, cluster_start} >= 17'(cl_end));
    assign sts.hit         = (key_rd_reg[15:0] == key_reg);
    assign sts.more        = (rd_idx_inc < (sdict_pkg::CNT_W + 1)'(end_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && in_entries && unsat
            && (slot_reg != sdict_pkg::SLOT_W'(sdict_pkg::ENT_BYTES - 1)))
        begin
            assembly_reg[slot_reg] <= blob_byte;
        end
        if (wr_en)
        begin
            key_mem[sdict_pkg::IDX_W'(eidx_reg)]  <= wr_key;
            link_mem[sdict_pkg::IDX_W'(eidx_reg)] <= wr_link;
        end
        if (rd_en)
        begin
            key_rd_reg  <= key_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
        end
        if (cmd.look_start)
        begin
            key_reg <= seq_key;
            end_reg <= cl_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            slot_reg     <= '0;
            eidx_reg     <= '0;
            declared_reg <= '0;
            loaded_reg   <= '0;
            rd_idx_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                if (byte_cnt_reg == sdict_pkg::BCNT_W'(2))
                begin
                    declared_reg[7:0] <= blob_byte;
                end
                if (byte_cnt_reg == sdict_pkg::BCNT_W'(3))
                begin
                    declared_reg[15:8] <= blob_byte;
                end
                if (cmd.emit_load)
                begin
                    byte_cnt_reg <= '0;
                    slot_reg     <= '0;
                    eidx_reg     <= '0;
                    loaded_reg   <= (status == sdict_pkg::LS_OK)
                                    ? sdict_pkg::CNT_W'(declared_reg) : '0;
                end
                else
                begin
                    byte_cnt_reg <= byte_cnt_inc;
                    if (byte_cnt_reg == '0)
                    begin
                        loaded_reg <= '0;
                    end
                    if (in_entries && unsat)
                    begin
                        if (slot_reg == sdict_pkg::SLOT_W'(sdict_pkg::ENT_BYTES - 1))
                        begin
                            slot_reg <= '0;
                            eidx_reg <= eidx_reg + 1'b1;
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                end
            end
            if (rd_en)
            begin
                rd_idx_reg <= rd_addr;
            end
            done_reg <= cmd.emit_load || cmd.emit_hit || cmd.emit_miss;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load || cmd.emit_hit || cmd.emit_miss)
        begin
            kind_reg   <= cmd.emit_load ? sdict_pkg::KIND_LOAD : sdict_pkg::KIND_LOOKUP;
            status_reg <= cmd.emit_load ? status : sdict_pkg::LS_OK;
            found_reg  <= cmd.emit_hit;
            if (cmd.emit_hit)
            begin
                index_reg <= 8'(rd_idx_reg);
                fmt_reg   <= key_rd_reg[23:16];
                seq_reg   <= key_rd_reg[15:0];
                coff_reg  <= link_rd_reg[55:40];
                ccnt_reg  <= link_rd_reg[39:24];
                nlen_reg  <= link_rd_reg[23:16];
                noff_reg  <= link_rd_reg[15:0];
            end
            else
            begin
                index_reg <= '0;
                fmt_reg   <= '0;
                seq_reg   <= '0;
                coff_reg  <= '0;
                ccnt_reg  <= '0;
                nlen_reg  <= '0;
                noff_reg  <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign result_kind  = kind_reg;
    assign load_status  = status_reg;
    assign found        = found_reg;
    assign entry_index  = index_reg;
    assign entry_format = fmt_reg;
    assign entry_seq    = seq_reg;
    assign child_offset = coff_reg;
    assign child_count  = ccnt_reg;
    assign name_length  = nlen_reg;
    assign name_offset  = noff_reg;

    `ASSERT_CLK(a_one_emit, $onehot0({cmd.emit_load, cmd.emit_hit, cmd.emit_miss}), "two results in one cycle")
    `ASSERT_CLK(a_hit_out, cmd.emit_hit |=> (done && found && result_kind == sdict_pkg::KIND_LOOKUP), "hit not reported")
    `ASSERT_NEVER(a_loaded_cap, loaded_reg > sdict_pkg::CNT_W'(sdict_pkg::MAX_ENTRIES), "loaded count above capacity")
    `ASSERT_CLK(a_scan_range, cmd.read_next |-> (rd_idx_inc < (sdict_pkg::CNT_W + 1)'(end_reg)), "scan past cluster end")

endmodule
